// File: rtl/stsg_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the
// sine tone sample generator. No dependencies.
package stsg_pkg;

  localparam int MAX_FRAMES      = 64;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;
  localparam int ROM_AW          = SINE_TABLE_BITS + 1;
  localparam int SIN_W           = 31;
  localparam int FRAME_COUNT_W   = 7;
  localparam int FRAMES_W        = $clog2(MAX_FRAMES + 1);
  localparam int SAMPLE_W        = 32;
  localparam int OQ_AW           = 2;
  localparam int OQ_DEPTH        = 1 << OQ_AW;
  localparam int OQ_CNT_W        = OQ_AW + 1;
  localparam int PADDR_W         = 3;

  typedef longint unsigned u64_t;

  localparam u64_t PI_HALF_Q30 = 64'd1686629713;

  localparam logic REG_IDX_PHASE_STEP = 1'b0;
  localparam logic REG_IDX_OUT_FORMAT = 1'b1;

  localparam u64_t TAYLOR_DIV [1:19] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342,
    64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056, 64'd1190,
    64'd1332, 64'd1482
  };

  typedef enum logic [2:0] {
    FMT_FLOAT32 = 3'd0,
    FMT_INT32   = 3'd1,
    FMT_INT16   = 3'd2,
    FMT_INT8    = 3'd3,
    FMT_UINT8   = 3'd4
  } fmt_e;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [2:0]  out_format;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic last;
  } meta_t;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } push_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } oq_item_t;

  typedef logic [SIN_W-1:0] sin_tab_t [0:QUARTER_LEN];

  // Taylor series in Q30, stop at the first zero term, clamp to [0, 1.0].
  function automatic logic [SIN_W-1:0] taylor_sin_q30(u64_t x);
    u64_t   x2;
    u64_t   term;
    longint sum;
    logic   done;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    done = 1'b0;
    for (int k = 1; k < 20; k++) begin
      if (!done) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
    return SIN_W'(sum);
  endfunction

  function automatic sin_tab_t build_sin_table();
    sin_tab_t tab;
    u64_t     x;
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      x = (u64_t'(i) * PI_HALF_Q30 + u64_t'(QUARTER_LEN >> 1)) >> SINE_TABLE_BITS;
      tab[i] = taylor_sin_q30(x);
    end
    return tab;
  endfunction

endpackage

// File: rtl/stsg_req_if.sv
// Request channel: one buffer request carrying the number of frames wanted.
// Depends on stsg_pkg.
interface stsg_req_if import stsg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FRAME_COUNT_W-1:0] frame_count;

  modport source(output valid, output frame_count, input ready);
  modport sink(input valid, input frame_count, output ready);
endinterface

// File: rtl/stsg_frame_if.sv
// Frame channel: one stereo sample pair plus the last-frame flag.
// Depends on stsg_pkg.
interface stsg_frame_if import stsg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] right_sample;
  logic                last_frame;

  modport source(output valid, output left_sample, output right_sample,
                 output last_frame, input ready);
  modport sink(input valid, input left_sample, input right_sample,
               input last_frame, output ready);
endinterface

// File: rtl/stsg_apb_regs.sv
// APB configuration registers: phase step and output format.
// Depends on stsg_pkg.
module stsg_apb_regs import stsg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_IDX_PHASE_STEP: cfg_d.phase_step = pwdata;
        REG_IDX_OUT_FORMAT: cfg_d.out_format = pwdata[2:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_PHASE_STEP: prdata = cfg_q.phase_step;
      REG_IDX_OUT_FORMAT: prdata = {29'd0, cfg_q.out_format};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/stsg_sine_rom.sv
// Quarter-wave sine ROM, Q30 entries, synchronous (registered) read.
// Depends on stsg_pkg (table builder runs at elaboration).
module stsg_sine_rom import stsg_pkg::*; (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ROM_AW-1:0] addr_i,
  output logic [SIN_W-1:0]  rdata_o
);

  localparam sin_tab_t SIN_TABLE = build_sin_table();

  logic [SIN_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= SIN_TABLE[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/stsg_fmt.sv
// Two-stage sample formatter: scale and leading-one search, then sign,
// float normalize and round. Depends on stsg_pkg.
module stsg_fmt import stsg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       out_format_i,
  input  meta_t            meta_i,
  input  logic [SIN_W-1:0] mag_i,
  output logic [1:0]       inflight_o,
  output push_t            push_o
);

  meta_t            s1_q;
  meta_t            s2_q, s2_d;
  logic [SIN_W-1:0] m2_q;
  logic [61:0]      prod_q, prod_d;
  logic [4:0]       lz_q, lz_d;
  logic [30:0]      mult;

  // Stage 1: ROM data is valid now.
  always_comb begin
    unique case (out_format_i)
      FMT_INT32:           mult = 31'h7FFF_FFFF;
      FMT_INT16:           mult = 31'd32767;
      FMT_INT8, FMT_UINT8: mult = 31'd127;
      default:             mult = '0;
    endcase
  end

  assign prod_d = mag_i * mult;

  always_comb begin
    lz_d = '0;
    for (int i = 0; i < SIN_W; i++) begin
      if (mag_i[i]) lz_d = 5'(i);
    end
  end

  always_comb begin
    s2_d     = s1_q;
    s2_d.neg = s1_q.neg && (mag_i != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= meta_i;
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m2_q   <= mag_i;
    prod_q <= prod_d;
    lz_q   <= lz_d;
  end

  // Stage 2: finish the selected format.
  logic [30:0] norm;
  logic [23:0] q24;
  logic        round_up;
  logic [24:0] qr;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [31:0] f32;
  logic [31:0] v;
  logic [31:0] sv;
  logic [37:0] base;
  logic [37:0] tot;
  logic [31:0] sample;

  always_comb begin
    norm     = m2_q << (5'd30 - lz_q);
    q24      = norm[30:7];
    round_up = norm[6] && ((|norm[5:0]) || q24[0]);
    qr       = {1'b0, q24} + 25'(round_up);
    expo     = 8'(lz_q) + 8'd97 + 8'(qr[24]);
    mant     = qr[24] ? 23'd0 : qr[22:0];
    f32      = (m2_q == '0) ? 32'd0 : {s2_q.neg, expo, mant};
    v        = prod_q[61:30];
    sv       = s2_q.neg ? (32'd0 - v) : v;
    base     = 38'd128 << 30;
    tot      = s2_q.neg ? (base - prod_q[37:0]) : (base + prod_q[37:0]);
    unique case (out_format_i)
      FMT_FLOAT32: sample = f32;
      FMT_INT32:   sample = sv;
      FMT_INT16:   sample = {16'd0, sv[15:0]};
      FMT_INT8:    sample = {24'd0, sv[7:0]};
      FMT_UINT8:   sample = {24'd0, tot[37:30]};
      default:     sample = '0;
    endcase
  end

  assign push_o.valid  = s2_q.valid;
  assign push_o.sample = sample;
  assign push_o.last   = s2_q.last;
  assign inflight_o    = 2'(s1_q.valid) + 2'(s2_q.valid);

endmodule

// File: rtl/stsg_out_fifo.sv
// Output queue for formatted frames; drives the frame channel.
// Depends on stsg_pkg and stsg_frame_if.
module stsg_out_fifo import stsg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  push_t               push_i,
  output logic [OQ_CNT_W-1:0] count_o,
  stsg_frame_if.source        frame_o
);

  oq_item_t            mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [OQ_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                pop;

  assign pop = frame_o.valid && frame_o.ready;

  always_comb begin
    wr_ptr_d = push_i.valid ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + OQ_CNT_W'(push_i.valid) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= '{sample: push_i.sample, last: push_i.last};
    end
  end

  assign frame_o.valid        = (cnt_q != '0);
  assign frame_o.left_sample  = mem_q[rd_ptr_q].sample;
  assign frame_o.right_sample = mem_q[rd_ptr_q].sample;
  assign frame_o.last_frame   = mem_q[rd_ptr_q].last;
  assign count_o              = cnt_q;

endmodule

// File: rtl/sine_tone_sample_generator_top.sv
// Stereo sine tone source. A request asks for 1..64 frames (larger counts are
// capped at 64, zero gives nothing and leaves the phase alone); the block
// then streams that many frames, flagging the final one with last_frame.
// Each frame is the sine of a 32-bit phase, looked up by truncation in a
// 1025-entry quarter-wave ROM (Q30), formatted per out_format as float32,
// int32, int16, int8 (truncated toward zero) or offset uint8; codes 5..7 give
// zero. Both channels carry the same value, and the phase advances by
// phase_step after every frame. Frames leave at one per cycle once the
// pipeline is running; a request's first frame passes the frame counter, ROM
// read and both formatter stages into the output queue. The rate is set by
// the single ROM read port, serving one frame per cycle, and by the issue
// credit against the 4-entry output queue when the sink stalls. A new
// request is taken as soon as the previous one has issued its last frame.
// Write phase_step and out_format only while the block is idle.
// Depends on stsg_pkg, stsg_req_if, stsg_frame_if and the stsg submodules.
module sine_tone_sample_generator_top import stsg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  stsg_req_if.sink           req_i,
  stsg_frame_if.source       frame_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t                cfg;
  logic [FRAMES_W-1:0] frames_left_q, frames_left_d;
  logic [FRAMES_W-1:0] sat_count;
  logic [31:0]         phase_q, phase_d;
  logic                req_fire;
  logic                issue;
  meta_t               issue_meta;
  logic [ROM_AW-1:0]   rom_addr;
  logic [SIN_W-1:0]    rom_data;
  logic [1:0]          inflight;
  logic [OQ_CNT_W-1:0] oq_cnt;
  logic [OQ_CNT_W:0]   committed;
  push_t               push;
  logic [SINE_TABLE_BITS-1:0] tab_idx;

  stsg_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Take a new request only when the previous one has issued all its frames.
  assign req_i.ready = (frames_left_q == '0);
  assign req_fire    = req_i.valid && req_i.ready;

  // Cap oversize counts at the buffer limit.
  always_comb begin
    if (32'(req_i.frame_count) > MAX_FRAMES) begin
      sat_count = FRAMES_W'(MAX_FRAMES);
    end else begin
      sat_count = FRAMES_W'(req_i.frame_count);
    end
  end

  // Issue a frame only when the output queue has room for everything
  // already in flight plus this one, so nothing in the pipeline must stall.
  assign committed = (OQ_CNT_W + 1)'(oq_cnt) + (OQ_CNT_W + 1)'(inflight);
  assign issue     = (frames_left_q != '0) && (committed < (OQ_CNT_W + 1)'(OQ_DEPTH));

  always_comb begin
    frames_left_d = frames_left_q;
    phase_d       = phase_q;
    if (req_fire) begin
      frames_left_d = sat_count;
    end else if (issue) begin
      frames_left_d = frames_left_q - 1'b1;
      phase_d       = phase_q + cfg.phase_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_left_q <= '0;
      phase_q       <= '0;
    end else begin
      frames_left_q <= frames_left_d;
      phase_q       <= phase_d;
    end
  end

  // Quadrant from the top two phase bits; odd quadrants read the table mirrored.
  assign tab_idx  = phase_q[29 -: SINE_TABLE_BITS];
  assign rom_addr = phase_q[30] ? (ROM_AW'(QUARTER_LEN) - ROM_AW'(tab_idx))
                                : ROM_AW'(tab_idx);

  assign issue_meta.valid = issue;
  assign issue_meta.neg   = phase_q[31];
  assign issue_meta.last  = (frames_left_q == FRAMES_W'(1));

  stsg_sine_rom u_rom (
    .clk_i  (clk_i),
    .rd_en_i(issue),
    .addr_i (rom_addr),
    .rdata_o(rom_data)
  );

  stsg_fmt u_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .out_format_i(cfg.out_format),
    .meta_i      (issue_meta),
    .mag_i       (rom_data),
    .inflight_o  (inflight),
    .push_o      (push)
  );

  stsg_out_fifo u_oq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .count_o(oq_cnt),
    .frame_o(frame_o)
  );

  // Queue occupancy plus frames in the pipeline never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed <= (OQ_CNT_W + 1)'(OQ_DEPTH))
    else $error("output queue credit overrun");

  // Every issued frame advances the phase by exactly one step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> (phase_q == $past(phase_q) + $past(cfg.phase_step)))
    else $error("phase did not advance by one step");

  // A taken request loads the capped frame count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (frames_left_q == $past(sat_count)))
    else $error("frame count not loaded on request");

endmodule
